### rtl/sftrb_pkg.sv
`default_nettype none

package sftrb_pkg;

	// action codes carried in the low bits of the input tuser
	typedef enum logic [2:0] {
		ACT_CLEAR = 3'd0,
		ACT_RECT  = 3'd1,
		ACT_CHAR  = 3'd2,
		ACT_LOAD  = 3'd3,
		ACT_READ  = 3'd4
	} action_t;

	// stream widths
	localparam int IN_TDATA_W  = 72;
	localparam int IN_TUSER_W  = 4;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_TUSER_W = 1;

	// printable character range
	localparam logic [7:0] CHAR_FIRST = 8'h20;
	localparam logic [7:0] CHAR_LAST  = 8'h7e;

	// glyph geometry, stored as last column and last row index
	localparam logic [2:0] SMALL_COL_LAST = 3'd5;
	localparam logic [2:0] LARGE_COL_LAST = 3'd7;
	localparam logic [3:0] SMALL_ROW_LAST = 4'd11;
	localparam logic [3:0] LARGE_ROW_LAST = 4'd15;
	localparam logic [8:0] SMALL_CHAR_W   = 9'd6;
	localparam logic [8:0] LARGE_CHAR_W   = 9'd8;

	// top row of a font byte sits in its msb
	localparam logic [7:0] FONT_TOP_MASK = 8'h80;

endpackage

`default_nettype wire

### rtl/sftrb_ram.sv
`default_nettype none

module sftrb_ram #(
	parameter int DEPTH = 2560,
	parameter int WIDTH = 16,
	parameter int AW    = 12
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, data held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### rtl/strip_framebuffer_text_rect_blitter_top.sv
// Strip framebuffer with text and rectangle drawing.
// Commands enter on the s_axis channel: tuser holds the action and the font
// select, tdata the position, size, color and font load fields. Every command
// gives exactly one result transfer on m_axis: tuser is the stopped flag,
// tdata the read pixel and the next cursor column.
// Pixels live in one STRIP_W x STRIP_H memory, glyph bytes in a second one;
// the pixel memory has a single write port, so drawing runs one pixel a cycle.
// An empty rectangle, a stopped char and an unused code go straight to the result.
// A new command is taken once the previous one has reached the output
// register, so a finished result may wait for the receiver while the next
// command is already running; a command that finishes while the output
// register is still full waits in its done state until the receiver takes it.
// Reset returns the control to idle with no result pending; the memory
// contents are undefined until written, so a clear and a font load come first.
`default_nettype none

module strip_framebuffer_text_rect_blitter_top #(
	parameter int STRIP_W     = 160,
	parameter int STRIP_H     = 16,
	parameter int GLYPH_COUNT = 95
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// pos_x, pos_y, rect_width, rect_height, color, char_code,
	// font_byte_index, font_byte_value, zero pad
	input  wire logic [sftrb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// action, large_font
	input  wire logic [sftrb_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// pixel_value, next_x, zero pad
	output logic      [sftrb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// status
	output logic      [sftrb_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

	localparam int PIX_DEPTH  = STRIP_W * STRIP_H;
	localparam int PAW        = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
	localparam int GIW        = (2 * GLYPH_COUNT > 1) ? $clog2(2 * GLYPH_COUNT) : 1;
	localparam int FONT_DEPTH = 2 * GLYPH_COUNT * 16;
	localparam int FAW        = GIW + 4;
	localparam int MW         = 8 + $clog2(STRIP_W + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RECT,
		ST_CHAR,
		ST_LOAD,
		ST_READ,
		ST_RWAIT,
		ST_DONE
	} state_t;

	state_t state_q;

	// input fields
	logic [2:0]  in_action;
	logic        in_large;
	logic [7:0]  in_x;
	logic [7:0]  in_y;
	logic [7:0]  in_w;
	logic [7:0]  in_h;
	logic [15:0] in_color;
	logic [7:0]  in_code;
	logic [3:0]  in_bidx;
	logic [7:0]  in_bval;

	assign in_action = s_axis_tuser[2:0];
	assign in_large  = s_axis_tuser[3];
	assign in_x      = s_axis_tdata[7:0];
	assign in_y      = s_axis_tdata[15:8];
	assign in_w      = s_axis_tdata[23:16];
	assign in_h      = s_axis_tdata[31:24];
	assign in_color  = s_axis_tdata[47:32];
	assign in_code   = s_axis_tdata[55:48];
	assign in_bidx   = s_axis_tdata[59:56];
	assign in_bval   = s_axis_tdata[67:60];

	logic accept;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// command decode in the accept cycle
	logic [MW-1:0]  start_full;
	logic [PAW-1:0] start_addr;
	logic [8:0]     x_ext;
	logic [8:0]     y_ext;
	logic [8:0]     x_end;
	logic [8:0]     y_end;
	logic [8:0]     col_end;
	logic [8:0]     row_end;
	logic           rect_empty;
	logic [8:0]     char_w;
	logic [8:0]     char_right;
	logic [7:0]     gidx;
	logic [8:0]     glyph_sum;
	logic           gidx_ok;
	logic           printable;
	logic           char_ok;
	logic           pos_ok;

	always_comb begin
		start_full = MW'(in_y) * MW'(STRIP_W) + MW'(in_x);
		start_addr = start_full[PAW-1:0];
		x_ext      = {1'b0, in_x};
		y_ext      = {1'b0, in_y};
		x_end      = x_ext + {1'b0, in_w};
		y_end      = y_ext + {1'b0, in_h};
		col_end    = (x_end > 9'(STRIP_W)) ? 9'(STRIP_W) : x_end;
		row_end    = (y_end > 9'(STRIP_H)) ? 9'(STRIP_H) : y_end;
		rect_empty = (x_ext >= col_end) || (y_ext >= row_end);
		char_w     = in_large ? sftrb_pkg::LARGE_CHAR_W : sftrb_pkg::SMALL_CHAR_W;
		char_right = x_ext + char_w;
		gidx       = (in_action == sftrb_pkg::ACT_LOAD) ? in_code
		                                                : in_code - sftrb_pkg::CHAR_FIRST;
		gidx_ok    = ({1'b0, gidx} < 9'(GLYPH_COUNT));
		glyph_sum  = in_large ? (9'(GLYPH_COUNT) + {1'b0, gidx}) : {1'b0, gidx};
		printable  = (in_code >= sftrb_pkg::CHAR_FIRST) && (in_code <= sftrb_pkg::CHAR_LAST);
		char_ok    = printable && gidx_ok && (char_right <= 9'(STRIP_W));
		pos_ok     = (x_ext < 9'(STRIP_W)) && (y_ext < 9'(STRIP_H));
	end

	// command registers
	logic [15:0]    raw_q;
	logic [7:0]     x_q;
	logic [8:0]     col_q;
	logic [8:0]     col_end_q;
	logic [8:0]     row_q;
	logic [8:0]     row_end_q;
	logic [8:0]     row_start_q;
	logic [PAW-1:0] addr_q;
	logic [PAW-1:0] base_q;
	logic [GIW-1:0] glyph_q;
	logic [2:0]     gcol_q;
	logic [3:0]     grow_q;
	logic [2:0]     col_last_q;
	logic [3:0]     row_last_q;
	logic [3:0]     bidx_q;
	logic [7:0]     bval_q;
	logic           flag_q;

	// char pipeline stage: font data returns in the cycle after the read
	logic           wr_valid_s1;
	logic [PAW-1:0] wr_addr_s1;
	logic [2:0]     bit_s1;
	logic           row_ok_s1;

	// result being built and output register
	logic        pend_status_q;
	logic [15:0] pend_pix_q;
	logic [8:0]  pend_nx_q;
	logic        out_valid_q;
	logic        out_status_q;
	logic [15:0] out_pix_q;
	logic [8:0]  out_nx_q;

	// memory ports
	logic           pix_we;
	logic [PAW-1:0] pix_wa;
	logic           pix_re;
	logic [15:0]    pix_rd;
	logic           font_we;
	logic           font_re;
	logic [FAW-1:0] font_wa;
	logic [FAW-1:0] font_ra;
	logic [7:0]     font_rd;

	// pixel write port: char pipeline, or clear and rectangle sweeps
	always_comb begin
		pix_we = 1'b0;
		pix_wa = addr_q;
		if (wr_valid_s1) begin
			pix_we = row_ok_s1 && ((font_rd & (sftrb_pkg::FONT_TOP_MASK >> bit_s1)) != 8'd0);
			pix_wa = wr_addr_s1;
		end else if ((state_q == ST_CLEAR) || (state_q == ST_RECT)) begin
			pix_we = 1'b1;
		end
	end

	assign pix_re  = (state_q == ST_READ);
	assign font_we = (state_q == ST_LOAD) && flag_q;
	assign font_wa = {glyph_q, bidx_q};
	assign font_re = (state_q == ST_CHAR);
	assign font_ra = {glyph_q, gcol_q, grow_q[3]};

	sftrb_ram #(
		.DEPTH (PIX_DEPTH),
		.WIDTH (16),
		.AW    (PAW)
	) u_pix_ram (
		.clk     (clk),
		.wr_en   (pix_we),
		.wr_addr (pix_wa),
		.wr_data (raw_q),
		.rd_en   (pix_re),
		.rd_addr (addr_q),
		.rd_data (pix_rd)
	);

	sftrb_ram #(
		.DEPTH (FONT_DEPTH),
		.WIDTH (8),
		.AW    (FAW)
	) u_font_ram (
		.clk     (clk),
		.wr_en   (font_we),
		.wr_addr (font_wa),
		.wr_data (bval_q),
		.rd_en   (font_re),
		.rd_addr (font_ra),
		.rd_data (font_rd)
	);

	// sequencer, char pipeline and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			wr_valid_s1   <= 1'b0;
			out_valid_q   <= 1'b0;
			raw_q         <= '0;
			x_q           <= '0;
			col_q         <= '0;
			col_end_q     <= '0;
			row_q         <= '0;
			row_end_q     <= '0;
			row_start_q   <= '0;
			addr_q        <= '0;
			base_q        <= '0;
			glyph_q       <= '0;
			gcol_q        <= '0;
			grow_q        <= '0;
			col_last_q    <= '0;
			row_last_q    <= '0;
			bidx_q        <= '0;
			bval_q        <= '0;
			flag_q        <= 1'b0;
			wr_addr_s1    <= '0;
			bit_s1        <= '0;
			row_ok_s1     <= 1'b0;
			pend_status_q <= 1'b0;
			pend_pix_q    <= '0;
			pend_nx_q     <= '0;
			out_status_q  <= 1'b0;
			out_pix_q     <= '0;
			out_nx_q      <= '0;
		end else begin
			// receiver takes the result
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			wr_valid_s1 <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						raw_q         <= {in_color[7:0], in_color[15:8]};
						x_q           <= in_x;
						col_q         <= x_ext;
						col_end_q     <= col_end;
						row_q         <= y_ext;
						row_start_q   <= y_ext;
						row_end_q     <= row_end;
						addr_q        <= start_addr;
						base_q        <= start_addr;
						glyph_q       <= glyph_sum[GIW-1:0];
						gcol_q        <= '0;
						grow_q        <= '0;
						col_last_q    <= in_large ? sftrb_pkg::LARGE_COL_LAST
						                          : sftrb_pkg::SMALL_COL_LAST;
						row_last_q    <= in_large ? sftrb_pkg::LARGE_ROW_LAST
						                          : sftrb_pkg::SMALL_ROW_LAST;
						bidx_q        <= in_bidx;
						bval_q        <= in_bval;
						pend_status_q <= 1'b0;
						pend_pix_q    <= '0;
						pend_nx_q     <= x_ext;
						case (sftrb_pkg::action_t'(in_action))
							sftrb_pkg::ACT_CLEAR: begin
								addr_q  <= '0;
								state_q <= ST_CLEAR;
							end
							sftrb_pkg::ACT_RECT: begin
								state_q <= rect_empty ? ST_DONE : ST_RECT;
							end
							sftrb_pkg::ACT_CHAR: begin
								if (char_ok) begin
									pend_nx_q <= char_right;
									state_q   <= ST_CHAR;
								end else begin
									pend_status_q <= 1'b1;
									state_q       <= ST_DONE;
								end
							end
							sftrb_pkg::ACT_LOAD: begin
								flag_q  <= gidx_ok;
								state_q <= ST_LOAD;
							end
							sftrb_pkg::ACT_READ: begin
								flag_q  <= pos_ok;
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end

				// one pixel a cycle over the whole strip
				ST_CLEAR: begin
					addr_q <= addr_q + PAW'(1);
					if (addr_q == PAW'(PIX_DEPTH - 1)) begin
						state_q <= ST_DONE;
					end
				end

				// row by row over the clipped rectangle
				ST_RECT: begin
					if (col_q + 9'd1 == col_end_q) begin
						if (row_q + 9'd1 == row_end_q) begin
							state_q <= ST_DONE;
						end else begin
							row_q  <= row_q + 9'd1;
							col_q  <= {1'b0, x_q};
							base_q <= base_q + PAW'(STRIP_W);
							addr_q <= base_q + PAW'(STRIP_W);
						end
					end else begin
						col_q  <= col_q + 9'd1;
						addr_q <= addr_q + PAW'(1);
					end
				end

				// column-major walk, font byte read now, pixel decided next cycle
				ST_CHAR: begin
					wr_valid_s1 <= 1'b1;
					wr_addr_s1  <= addr_q;
					bit_s1      <= grow_q[2:0];
					row_ok_s1   <= (row_q < 9'(STRIP_H));
					if (grow_q == row_last_q) begin
						grow_q <= '0;
						row_q  <= row_start_q;
						if (gcol_q == col_last_q) begin
							state_q <= ST_DONE;
						end else begin
							gcol_q <= gcol_q + 3'd1;
							base_q <= base_q + PAW'(1);
							addr_q <= base_q + PAW'(1);
						end
					end else begin
						grow_q <= grow_q + 4'd1;
						row_q  <= row_q + 9'd1;
						addr_q <= addr_q + PAW'(STRIP_W);
					end
				end

				ST_LOAD: begin
					state_q <= ST_DONE;
				end

				ST_READ: begin
					state_q <= ST_RWAIT;
				end

				ST_RWAIT: begin
					pend_pix_q <= flag_q ? pix_rd : 16'd0;
					state_q    <= ST_DONE;
				end

				// hand the result to the output register once it is free
				ST_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= pend_status_q;
						out_pix_q    <= pend_pix_q;
						out_nx_q     <= pend_nx_q;
						state_q      <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_nx_q, out_pix_q};
	assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

### rtl/sftrb_chk.sv
`default_nettype none

module sftrb_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_axis_tvalid,
	input wire logic                              s_axis_tready,
	input wire logic [sftrb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input wire logic [sftrb_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready,
	input wire logic [sftrb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic [sftrb_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

	// a result stays offered until the receiver takes it
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// a stalled result does not change
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// one command at a time: no transfer right after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("command taken while busy");

	// a stopped char never carries a pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[15:0] == 16'd0)
		else $error("stopped result with pixel data");

	// next column stays within one glyph past the last column, pad is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[24:16] <= 9'd263) && (m_axis_tdata[31:25] == 7'd0))
		else $error("next column out of range");

endmodule

bind strip_framebuffer_text_rect_blitter_top sftrb_chk u_sftrb_chk (.*);

`default_nettype wire
